>>> rtl/smaf_pkg.sv
// ----------------------------------------------------------------------------
// smaf_pkg: shared types and constants
// Datapath widths, arctangent table, latitude fraction table and the
// result record of one body pipeline.
// ----------------------------------------------------------------------------
package smaf_pkg;

   localparam int XW = 36;
   localparam int ZW = 35;
   localparam int ATAN_ENTRIES = 24;
   localparam int DIV_STEPS = 16;

   localparam logic [29:0] GAIN_Q30 = 30'd652032874;
   localparam logic [15:0] DAY_UNITS = 16'd49152;
   localparam logic [15:0] NOON_UNITS = 16'd24576;
   localparam logic [15:0] ALT_LIMIT = 16'd11520;
   localparam logic [15:0] AZ_LIMIT = 16'd23040;

   typedef enum logic [2:0] {
      REG_LATITUDE    = 3'd0,
      REG_COMPASS_YAW = 3'd1,
      REG_BAND        = 3'd2,
      REG_SUN_PEAK    = 3'd3,
      REG_MOON_PEAK   = 3'd4,
      REG_MOON_OFFSET = 3'd5,
      REG_MOON_TILT   = 3'd6
   } reg_index_type;

   typedef logic [31:0] atan_table_type [0:ATAN_ENTRIES-1];

   localparam atan_table_type ATAN_TURNS = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef logic [21:0] lat_frac_table_type [0:44];

   function automatic lat_frac_table_type build_lat_frac();
      lat_frac_table_type tbl;
      for (int b = 0; b < 45; b++) begin
         tbl[b] = 22'((longint'(b) * 64'd4194304 + 64'd22) / 45);
      end
      return tbl;
   endfunction

   localparam lat_frac_table_type LAT_FRAC = build_lat_frac();

   typedef struct packed {
      logic signed [14:0] pitch;
      logic signed [16:0] yaw;
      logic [15:0]        intensity;
      logic               visible;
   } body_out_type;

   function automatic logic signed [15:0] to_deg128(logic signed [ZW-1:0] a,
                                                    logic [15:0] lim);
      logic signed [ZW+6:0] m;
      logic signed [ZW+6:0] s;
      logic signed [ZW+6:0] l;
      m = signed'((ZW+7)'(a)) * $signed((ZW+7)'(45)) + $signed((ZW+7)'(2097152));
      s = m >>> 22;
      l = $signed((ZW+7)'(lim));
      if (s > l) begin
         return $signed(lim);
      end else if (s < -l) begin
         return -$signed(lim);
      end
      return s[15:0];
   endfunction

endpackage

>>> rtl/smaf_cordic_cell.sv
// ----------------------------------------------------------------------------
// smaf_cordic_cell: one CORDIC micro-rotation
// Rotation or vectoring step with a fixed shift, registered on advance.
// ----------------------------------------------------------------------------
module smaf_cordic_cell #(
   parameter bit VECTOR = 1'b0,
   parameter int SHIFT  = 0,
   parameter int AUX_W  = 1
) (
   input  logic                           clock,
   input  logic                           adv,
   input  logic signed [smaf_pkg::XW-1:0] src_x,
   input  logic signed [smaf_pkg::XW-1:0] src_y,
   input  logic signed [smaf_pkg::ZW-1:0] src_z,
   input  logic [AUX_W-1:0]               src_aux,
   output logic signed [smaf_pkg::XW-1:0] dst_x,
   output logic signed [smaf_pkg::XW-1:0] dst_y,
   output logic signed [smaf_pkg::ZW-1:0] dst_z,
   output logic [AUX_W-1:0]               dst_aux
);
   import smaf_pkg::*;

   localparam logic signed [ZW-1:0] ATAN = $signed(ZW'(ATAN_TURNS[SHIFT]));

   logic               dir;
   logic signed [XW-1:0] x_in, y_in, x_ff, y_ff;
   logic signed [ZW-1:0] z_in, z_ff;
   logic [AUX_W-1:0]     aux_ff;

   always_comb begin
      dir = VECTOR ? src_y[XW-1] : !src_z[ZW-1];
      if (dir) begin
         x_in = src_x - (src_y >>> SHIFT);
         y_in = src_y + (src_x >>> SHIFT);
         z_in = src_z - ATAN;
      end else begin
         x_in = src_x + (src_y >>> SHIFT);
         y_in = src_y - (src_x >>> SHIFT);
         z_in = src_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         aux_ff <= src_aux;
      end
   end

   assign dst_x   = x_ff;
   assign dst_y   = y_ff;
   assign dst_z   = z_ff;
   assign dst_aux = aux_ff;

endmodule

>>> rtl/smaf_div_cell.sv
// ----------------------------------------------------------------------------
// smaf_div_cell: one restoring division step
// Doubles the remainder, subtracts the divisor when it fits, shifts in a bit.
// ----------------------------------------------------------------------------
module smaf_div_cell #(
   parameter int AUX_W = 1
) (
   input  logic              clock,
   input  logic              adv,
   input  logic [14:0]       src_rem,
   input  logic [14:0]       src_den,
   input  logic [15:0]       src_q,
   input  logic [AUX_W-1:0]  src_aux,
   output logic [14:0]       dst_rem,
   output logic [14:0]       dst_den,
   output logic [15:0]       dst_q,
   output logic [AUX_W-1:0]  dst_aux
);
   import smaf_pkg::*;

   logic [15:0]      twice;
   logic             fits;
   logic [14:0]      rem_in, rem_ff, den_ff;
   logic [15:0]      q_ff;
   logic [AUX_W-1:0] aux_ff;

   always_comb begin
      twice  = {src_rem, 1'b0};
      fits   = twice >= {1'b0, src_den};
      rem_in = fits ? 15'(twice - {1'b0, src_den}) : twice[14:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         den_ff <= src_den;
         q_ff   <= {src_q[14:0], fits};
         aux_ff <= src_aux;
      end
   end

   assign dst_rem = rem_ff;
   assign dst_den = den_ff;
   assign dst_q   = q_ff;
   assign dst_aux = aux_ff;

endmodule

>>> rtl/smaf_body.sv
// ----------------------------------------------------------------------------
// smaf_body: light angles and fade of one body
// Hour angle and latitude, two sine/cosine chains, two vectoring chains,
// degree conversion and a division chain for the twilight fade.
// ----------------------------------------------------------------------------
module smaf_body #(
   parameter int STAGES = 16
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [15:0]                   t_val,
   input  logic signed [15:0]            lat,
   input  logic [15:0]                   peak,
   input  logic [13:0]                   band,
   input  logic signed [15:0]            compass,
   output smaf_pkg::body_out_type        result
);
   import smaf_pkg::*;

   localparam int DAUX_W = 34;

   // angle stage
   logic signed [16:0] d;
   logic [14:0]        mag;
   logic [30:0]        prod3;
   logic [13:0]        q3;
   logic [15:0]        rem3_w;
   logic [17:0]        hfrac;
   logic [31:0]        hmag, h_in, h_ff;
   logic [15:0]        la;
   logic [31:0]        prodl;
   logic [9:0]         ql;
   logic [15:0]        bl_w;
   logic [5:0]         bl;
   logic [31:0]        pmag, p_in, p_ff;

   always_comb begin
      d      = $signed({1'b0, t_val}) - $signed({1'b0, NOON_UNITS});
      mag    = d[16] ? 15'(-d) : d[14:0];
      prod3  = mag * 16'd43691;
      q3     = prod3[30:17];
      rem3_w = {1'b0, mag} - 16'({2'b0, q3} * 16'd3);
      case (rem3_w[1:0])
         2'd1:    hfrac = 18'd87381;
         2'd2:    hfrac = 18'd174763;
         default: hfrac = 18'd0;
      endcase
      hmag  = {q3, 18'd0} + {14'd0, hfrac};
      h_in  = d[16] ? 32'd0 - hmag : hmag;
      la    = lat[15] ? 16'(-lat) : 16'(lat);
      prodl = la * 16'd46604;
      ql    = prodl[30:21];
      bl_w  = la - 16'({6'd0, ql} * 16'd45);
      bl    = bl_w[5:0];
      pmag  = {ql, LAT_FRAC[bl]};
      p_in  = lat[15] ? 32'd0 - pmag : pmag;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_ff <= h_in;
         p_ff <= p_in;
      end
   end

   // sine and cosine chains
   logic [31:0] h_sum, h_fold, p_sum, p_fold;
   logic signed [XW-1:0] hx [0:STAGES];
   logic signed [XW-1:0] hy [0:STAGES];
   logic signed [ZW-1:0] hz [0:STAGES];
   logic [0:0]           ha [0:STAGES];
   logic signed [XW-1:0] px [0:STAGES];
   logic signed [XW-1:0] py [0:STAGES];
   logic signed [ZW-1:0] pz [0:STAGES];
   logic [0:0]           pa [0:STAGES];

   always_comb begin
      h_sum  = h_ff + 32'h4000_0000;
      h_fold = h_sum[31] ? h_ff + 32'h8000_0000 : h_ff;
      p_sum  = p_ff + 32'h4000_0000;
      p_fold = p_sum[31] ? p_ff + 32'h8000_0000 : p_ff;
      hx[0]  = $signed(XW'(GAIN_Q30));
      hy[0]  = '0;
      hz[0]  = $signed({{(ZW-32){h_fold[31]}}, h_fold});
      ha[0]  = h_sum[31];
      px[0]  = $signed(XW'(GAIN_Q30));
      py[0]  = '0;
      pz[0]  = $signed({{(ZW-32){p_fold[31]}}, p_fold});
      pa[0]  = p_sum[31];
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      smaf_cordic_cell #(.VECTOR(1'b0), .SHIFT(i), .AUX_W(1)) u_hour (
         .clock(clock), .adv(adv),
         .src_x(hx[i]), .src_y(hy[i]), .src_z(hz[i]), .src_aux(ha[i]),
         .dst_x(hx[i+1]), .dst_y(hy[i+1]), .dst_z(hz[i+1]), .dst_aux(ha[i+1])
      );
      smaf_cordic_cell #(.VECTOR(1'b0), .SHIFT(i), .AUX_W(1)) u_lat (
         .clock(clock), .adv(adv),
         .src_x(px[i]), .src_y(py[i]), .src_z(pz[i]), .src_aux(pa[i]),
         .dst_x(px[i+1]), .dst_y(py[i+1]), .dst_z(pz[i+1]), .dst_aux(pa[i+1])
      );
   end

   // products
   logic signed [XW-1:0] ch_w, sh_w, cp_w, sp_w;
   logic signed [31:0]   ch, sh, cp, sp;
   logic signed [63:0]   prod_cs, prod_cc;
   logic signed [XW-1:0] ax_in, ay_in, ys_in, ax_ff, ay_ff, ys_ff;

   always_comb begin
      ch_w    = ha[STAGES][0] ? -hx[STAGES] : hx[STAGES];
      sh_w    = ha[STAGES][0] ? -hy[STAGES] : hy[STAGES];
      cp_w    = pa[STAGES][0] ? -px[STAGES] : px[STAGES];
      sp_w    = pa[STAGES][0] ? -py[STAGES] : py[STAGES];
      ch      = ch_w[31:0];
      sh      = sh_w[31:0];
      cp      = cp_w[31:0];
      sp      = sp_w[31:0];
      prod_cs = ch * sp;
      prod_cc = cp * ch;
      ax_in   = -XW'(prod_cs >>> 30);
      ay_in   = -signed'(XW'(sh));
      ys_in   = XW'(prod_cc >>> 30);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         ys_ff <= ys_in;
      end
   end

   // azimuth vectoring chain
   logic signed [XW-1:0] ux [0:STAGES];
   logic signed [XW-1:0] uy [0:STAGES];
   logic signed [ZW-1:0] uz [0:STAGES];
   logic [XW:0]          ua [0:STAGES];

   always_comb begin
      ux[0] = ax_ff[XW-1] ? -ax_ff : ax_ff;
      uy[0] = ax_ff[XW-1] ? -ay_ff : ay_ff;
      if (!ax_ff[XW-1]) begin
         uz[0] = '0;
      end else if (!ay_ff[XW-1]) begin
         uz[0] = $signed(ZW'(64'h8000_0000));
      end else begin
         uz[0] = -$signed(ZW'(64'h8000_0000));
      end
      ua[0] = {(ax_ff == '0) && (ay_ff == '0), ys_ff};
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_az
      smaf_cordic_cell #(.VECTOR(1'b1), .SHIFT(i), .AUX_W(XW+1)) u_cell (
         .clock(clock), .adv(adv),
         .src_x(ux[i]), .src_y(uy[i]), .src_z(uz[i]), .src_aux(ua[i]),
         .dst_x(ux[i+1]), .dst_y(uy[i+1]), .dst_z(uz[i+1]), .dst_aux(ua[i+1])
      );
   end

   // gain correction and azimuth conversion
   logic [61:0]          prod_g;
   logic [31:0]          rg_in, rg_ff;
   logic signed [ZW-1:0] az;
   logic signed [15:0]   az128_in, az128_ff;
   logic signed [XW-1:0] ys2_ff;

   always_comb begin
      prod_g   = ux[STAGES][31:0] * GAIN_Q30;
      rg_in    = prod_g[61:30];
      az       = ua[STAGES][XW] ? '0 : uz[STAGES];
      az128_in = to_deg128(az, AZ_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rg_ff    <= rg_in;
         ys2_ff   <= ua[STAGES][XW-1:0];
         az128_ff <= az128_in;
      end
   end

   // altitude vectoring chain
   logic signed [XW-1:0] vx [0:STAGES];
   logic signed [XW-1:0] vy [0:STAGES];
   logic signed [ZW-1:0] vz [0:STAGES];
   logic [16:0]          va [0:STAGES];

   always_comb begin
      vx[0] = $signed({{(XW-32){1'b0}}, rg_ff});
      vy[0] = ys2_ff;
      vz[0] = '0;
      va[0] = {(rg_ff == '0) && (ys2_ff == '0), az128_ff};
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_alt
      smaf_cordic_cell #(.VECTOR(1'b1), .SHIFT(i), .AUX_W(17)) u_cell (
         .clock(clock), .adv(adv),
         .src_x(vx[i]), .src_y(vy[i]), .src_z(vz[i]), .src_aux(va[i]),
         .dst_x(vx[i+1]), .dst_y(vy[i+1]), .dst_z(vz[i+1]), .dst_aux(va[i+1])
      );
   end

   // fade set-up
   logic signed [ZW-1:0] alt;
   logic signed [15:0]   alt128;
   logic [13:0]          band_e;
   logic signed [16:0]   num;
   logic [14:0]          den;
   logic signed [16:0]   yaw;
   logic [14:0]          pitch;
   logic                 c_zero, c_full;
   logic [14:0]          rem_ff, den_ff;
   logic [DAUX_W-1:0]    daux_ff;

   always_comb begin
      alt    = va[STAGES][16] ? '0 : vz[STAGES];
      alt128 = to_deg128(alt, ALT_LIMIT);
      band_e = (band == '0) ? 14'd1 : band;
      num    = signed'(17'(alt128)) + $signed({3'b0, band_e});
      den    = {band_e, 1'b0};
      c_zero = num <= 17'sd0;
      c_full = num >= $signed({2'b0, den});
      yaw    = signed'(17'(compass)) + signed'(17'(signed'(va[STAGES][15:0])));
      pitch  = 15'(-alt128);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= num[14:0];
         den_ff  <= den;
         daux_ff <= {c_zero, c_full, yaw, pitch};
      end
   end

   // division chain
   logic [14:0]       dr [0:DIV_STEPS];
   logic [14:0]       dd [0:DIV_STEPS];
   logic [15:0]       dq [0:DIV_STEPS];
   logic [DAUX_W-1:0] da [0:DIV_STEPS];

   assign dr[0] = rem_ff;
   assign dd[0] = den_ff;
   assign dq[0] = '0;
   assign da[0] = daux_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      smaf_div_cell #(.AUX_W(DAUX_W)) u_cell (
         .clock(clock), .adv(adv),
         .src_rem(dr[i]), .src_den(dd[i]), .src_q(dq[i]), .src_aux(da[i]),
         .dst_rem(dr[i+1]), .dst_den(dd[i+1]), .dst_q(dq[i+1]), .dst_aux(da[i+1])
      );
   end

   // intensity
   logic [16:0]  fade;
   logic [32:0]  prod_i;
   body_out_type result_in, result_ff;

   always_comb begin
      if (da[DIV_STEPS][33]) begin
         fade = '0;
      end else if (da[DIV_STEPS][32]) begin
         fade = 17'h1_0000;
      end else begin
         fade = {1'b0, dq[DIV_STEPS]};
      end
      prod_i              = peak * fade + 33'd32768;
      result_in.pitch     = $signed(da[DIV_STEPS][14:0]);
      result_in.yaw       = $signed(da[DIV_STEPS][31:15]);
      result_in.intensity = prod_i[31:16];
      result_in.visible   = fade != '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> rtl/sun_moon_angles_and_fade_core.sv
// ----------------------------------------------------------------------------
// sun_moon_angles_and_fade_core: sun and moon light angles with fade
// Equinox altitude, azimuth and twilight intensity for both bodies.
// ----------------------------------------------------------------------------
// A request on req_ carries a time of day in 1/2048 hour. Each request gives
// one response on rsp_ with pitch, yaw, intensity and visible flag for the
// sun and for the moon. Registers must be written on csr_ only while no request
// is in flight; the block does not enforce this. An index beyond the last
// register is ignored. Throughput: one request per cycle while rsp_ is not
// held. The pipeline runs through the three CORDIC cell chains (sine
// and cosine, azimuth, altitude) and the 16-step division chain of the fade.
// When the receiver holds rsp_tready low with a response waiting, the whole
// pipeline holds and req_tready drops; it takes a new request in the cycle
// the waiting response is taken.
// Reset empties the pipeline and loads the register defaults; it takes
// effect at once, with no clearing pass.
// ----------------------------------------------------------------------------
module sun_moon_angles_and_fade_core #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // time_of_day
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // sun_pitch, sun_yaw, sun_intensity, sun_visible,
   // moon_pitch, moon_yaw, moon_intensity, moon_visible, zero pad
   output logic [103:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [16:0]  csr_wdata
);
   import smaf_pkg::*;

   localparam int LAT = 3 * CORDIC_STAGES + 22;

   logic [14:0] latitude_ff;
   logic [15:0] compass_ff;
   logic [13:0] band_ff;
   logic [15:0] sun_peak_ff;
   logic [15:0] moon_peak_ff;
   logic [16:0] moon_offset_ff;
   logic [14:0] moon_tilt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         latitude_ff    <= 15'd0;
         compass_ff     <= 16'd0;
         band_ff        <= 14'd768;
         sun_peak_ff    <= 16'd2560;
         moon_peak_ff   <= 16'd51;
         moon_offset_ff <= 17'd24576;
         moon_tilt_ff   <= 15'd0;
      end else if (csr_we) begin
         case (csr_index)
            REG_LATITUDE:    latitude_ff    <= csr_wdata[14:0];
            REG_COMPASS_YAW: compass_ff     <= csr_wdata[15:0];
            REG_BAND:        band_ff        <= csr_wdata[13:0];
            REG_SUN_PEAK:    sun_peak_ff    <= csr_wdata[15:0];
            REG_MOON_PEAK:   moon_peak_ff   <= csr_wdata[15:0];
            REG_MOON_OFFSET: moon_offset_ff <= csr_wdata;
            REG_MOON_TILT:   moon_tilt_ff   <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   logic [LAT-1:0] valid_ff;
   logic           adv;

   assign adv        = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAT-2:0], req_tvalid};
      end
   end

   logic [15:0]        t_in, t_ff, mt_in, mt_ff;
   logic signed [17:0] ms;

   always_comb begin
      t_in = (req_tdata >= DAY_UNITS) ? req_tdata - DAY_UNITS : req_tdata;
      ms   = $signed({2'b0, t_in}) + signed'(18'($signed(moon_offset_ff)));
      if (ms < -18'sd49152) begin
         mt_in = 16'(ms + 18'sd98304);
      end else if (ms < 18'sd0) begin
         mt_in = 16'(ms + 18'sd49152);
      end else if (ms < 18'sd49152) begin
         mt_in = 16'(ms);
      end else if (ms < 18'sd98304) begin
         mt_in = 16'(ms - 18'sd49152);
      end else begin
         mt_in = 16'(ms - 18'sd98304);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff  <= t_in;
         mt_ff <= mt_in;
      end
   end

   logic signed [15:0] sun_lat, moon_lat;
   body_out_type       sun_res, moon_res;

   assign sun_lat  = signed'(16'($signed(latitude_ff)));
   assign moon_lat = signed'(16'($signed(latitude_ff))) +
                     signed'(16'($signed(moon_tilt_ff)));

   smaf_body #(.STAGES(CORDIC_STAGES)) u_sun (
      .clock(clock), .adv(adv), .t_val(t_ff), .lat(sun_lat),
      .peak(sun_peak_ff), .band(band_ff), .compass($signed(compass_ff)),
      .result(sun_res)
   );

   smaf_body #(.STAGES(CORDIC_STAGES)) u_moon (
      .clock(clock), .adv(adv), .t_val(mt_ff), .lat(moon_lat),
      .peak(moon_peak_ff), .band(band_ff), .compass($signed(compass_ff)),
      .result(moon_res)
   );

   assign rsp_tdata = {6'd0,
                       moon_res.visible, moon_res.intensity, moon_res.yaw, moon_res.pitch,
                       sun_res.visible, sun_res.intensity, sun_res.yaw, sun_res.pitch};

endmodule

>>> tb/sv/sun_moon_angles_and_fade_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sun_moon_angles_and_fade_core_test: self-checking bench for the sun and moon core
// Requests carrying a time of day stream into the core. A bit-exact CORDIC
// predictor works out the pitch, yaw, intensity and visible flag of both
// bodies for each accepted request. Responses are checked in order, field by
// field. Register settings change between phases and cover the extremes,
// a zero band and latitudes past the pole. Both channels idle at random, and
// one long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module sun_moon_angles_and_fade_core_test;
   import smaf_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int IDLE_LIMIT = 20000;

   typedef enum logic [1:0] {ENTRY_REQUEST, ENTRY_WRITE, ENTRY_DRAIN} entry_kind_type;

   typedef struct {
      entry_kind_type kind;
      logic [15:0]    tod;
      logic [2:0]     index;
      logic [16:0]    value;
      int             gap;
   } entry_type;

   typedef struct {
      body_out_type sun;
      body_out_type moon;
   } sky_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;   // time_of_day
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // sun_pitch, sun_yaw, sun_intensity, sun_visible,
   // moon_pitch, moon_yaw, moon_intensity, moon_visible, zero pad
   logic [103:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [16:0]  csr_wdata = '0;

   entry_type pending[$];
   sky_type   sky_expected[$];
   int        errors = 0;
   int        responses = 0;

   logic signed [14:0] latitude_r = 15'sd0;
   logic signed [15:0] compass_r = 16'sd0;
   logic [13:0]        band_r = 14'd768;
   logic [15:0]        sun_peak_r = 16'd2560;
   logic [15:0]        moon_peak_r = 16'd51;
   logic signed [16:0] moon_offset_r = 17'sd24576;
   logic signed [14:0] moon_tilt_r = 15'sd0;

   sun_moon_angles_and_fade_core dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void rotate_sincos(input logic [31:0] ang, output longint c,
                                         output longint s);
      longint x, y, z, xn, yn;
      bit     neg;
      x = longint'(GAIN_Q30);
      y = 0;
      neg = 0;
      if (((ang + 32'h4000_0000) & 32'h8000_0000) != 0) begin
         ang = ang + 32'h8000_0000;
         neg = 1;
      end
      z = longint'($signed(ang));
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            xn = x - (y >>> i);
            yn = y + (x >>> i);
            z = z - longint'(ATAN_TURNS[i]);
         end else begin
            xn = x + (y >>> i);
            yn = y - (x >>> i);
            z = z + longint'(ATAN_TURNS[i]);
         end
         x = xn;
         y = yn;
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endfunction

   function automatic void vector_angle(input longint x, input longint y, output longint ang,
                                        output longint mag);
      longint z, xn, yn;
      z = 0;
      if (x == 0 && y == 0) begin
         ang = 0;
         mag = 0;
         return;
      end
      if (x < 0) begin
         z = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         if (y < 0) begin
            xn = x - (y >>> i);
            yn = y + (x >>> i);
            z = z - longint'(ATAN_TURNS[i]);
         end else begin
            xn = x + (y >>> i);
            yn = y - (x >>> i);
            z = z + longint'(ATAN_TURNS[i]);
         end
         x = xn;
         y = yn;
      end
      ang = z;
      mag = x;
   endfunction

   function automatic longint clamp_deg(longint a, longint lim);
      longint v;
      v = (a * 45 + 2097152) >>> 22;
      return v < -lim ? -lim : (v > lim ? lim : v);
   endfunction

   function automatic body_out_type predict_body(longint t, longint lat, longint peak);
      body_out_type o;
      longint d, h, p, ch, sh, cp, sp, az, r, alt, unused, alt128, az128;
      longint band, num, den, fade;
      d = t - 24576;
      h = ((d < 0 ? -d : d) * 262144 + 1) / 3;
      if (d < 0) h = -h;
      p = ((lat < 0 ? -lat : lat) * 4194304 + 22) / 45;
      if (lat < 0) p = -p;
      rotate_sincos(h[31:0], ch, sh);
      rotate_sincos(p[31:0], cp, sp);
      vector_angle(-((ch * sp) >>> 30), -sh, az, r);
      r = (r * longint'(GAIN_Q30)) >>> 30;
      vector_angle(r, (cp * ch) >>> 30, alt, unused);
      alt128 = clamp_deg(alt, 11520);
      az128 = clamp_deg(az, 23040);
      band = (band_r == 0) ? 1 : longint'(band_r);
      num = alt128 + band;
      den = 2 * band;
      if (num <= 0) fade = 0;
      else if (num >= den) fade = 65536;
      else fade = (num * 65536) / den;
      o.pitch = 15'(-alt128);
      o.yaw = 17'(longint'(compass_r) + az128);
      o.intensity = 16'((peak * fade + 32768) >>> 16);
      o.visible = fade > 0;
      return o;
   endfunction

   function automatic sky_type predict_sky(logic [15:0] tod);
      sky_type s;
      longint t, mt;
      t = longint'(tod) % 49152;
      mt = (t + longint'(moon_offset_r)) % 49152;
      if (mt < 0) mt += 49152;
      s.sun = predict_body(t, longint'(latitude_r), longint'(sun_peak_r));
      s.moon = predict_body(mt, longint'(latitude_r) + longint'(moon_tilt_r),
                            longint'(moon_peak_r));
      return s;
   endfunction

   function automatic void apply_register(logic [2:0] index, logic [16:0] value);
      case (reg_index_type'(index))
         REG_LATITUDE:    latitude_r = value[14:0];
         REG_COMPASS_YAW: compass_r = value[15:0];
         REG_BAND:        band_r = value[13:0];
         REG_SUN_PEAK:    sun_peak_r = value[15:0];
         REG_MOON_PEAK:   moon_peak_r = value[15:0];
         REG_MOON_OFFSET: moon_offset_r = value;
         REG_MOON_TILT:   moon_tilt_r = value[14:0];
         default: ;
      endcase
   endfunction

   // driver
   int wait_count = 0;
   always @(posedge clock) begin
      entry_type e;
      logic      next_valid;
      logic      next_we;
      logic      took;
      next_we = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         took = req_tvalid && req_tready;
         if (took) begin
            sky_expected.push_back(predict_sky(req_tdata));
         end
         next_valid = 1'b0;
         if (wait_count > 0) begin
            wait_count--;
         end else if (pending.size() > 0) begin
            e = pending[0];
            case (e.kind)
               ENTRY_REQUEST: begin
                  if (e.gap > 0) begin
                     wait_count = e.gap - 1;
                     pending[0].gap = 0;
                  end else begin
                     void'(pending.pop_front());
                     req_tdata <= e.tod;
                     next_valid = 1'b1;
                  end
               end
               ENTRY_WRITE: begin
                  if (sky_expected.size() == 0 && !took) begin
                     void'(pending.pop_front());
                     next_we = 1'b1;
                     csr_index <= e.index;
                     csr_wdata <= e.value;
                     apply_register(e.index, e.value);
                  end
               end
               default: begin
                  if (sky_expected.size() == 0 && !took) void'(pending.pop_front());
               end
            endcase
         end
         req_tvalid <= next_valid;
      end
      csr_we <= next_we;
   end

   task automatic check_body(string name, body_out_type want, body_out_type got);
      if (want.pitch !== got.pitch) begin
         $error("%s_pitch expected %0d actual %0d", name, want.pitch, got.pitch);
         errors++;
      end
      if (want.yaw !== got.yaw) begin
         $error("%s_yaw expected %0d actual %0d", name, want.yaw, got.yaw);
         errors++;
      end
      if (want.intensity !== got.intensity) begin
         $error("%s_intensity expected %0d actual %0d", name, want.intensity, got.intensity);
         errors++;
      end
      if (want.visible !== got.visible) begin
         $error("%s_visible expected %0d actual %0d", name, want.visible, got.visible);
         errors++;
      end
   endtask

   // monitor
   int  stall = 0;
   bit  long_hold_done = 0;
   always @(posedge clock) begin
      sky_type      want;
      body_out_type sun_got, moon_got;
      int           roll;
      if (!reset && rsp_tvalid && rsp_tready) begin
         sun_got = '{rsp_tdata[14:0], rsp_tdata[31:15], rsp_tdata[47:32], rsp_tdata[48]};
         moon_got = '{rsp_tdata[63:49], rsp_tdata[80:64], rsp_tdata[96:81], rsp_tdata[97]};
         responses++;
         if (sky_expected.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            want = sky_expected.pop_front();
            check_body("sun", want.sun, sun_got);
            check_body("moon", want.moon, moon_got);
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall > 0) begin
         stall--;
         rsp_tready <= 1'b0;
      end else begin
         if (responses >= 400 && !long_hold_done) begin
            long_hold_done = 1;
            stall = 500;
         end else if (responses < 700 || responses > 900) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) stall = $urandom_range(1, 3);
            else if (roll < 12) stall = $urandom_range(10, 120);
         end
         rsp_tready <= (stall == 0);
      end
   end

   // watchdog
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we ||
          reset || pending.size() == 0 && sky_expected.size() == 0) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** sun_moon_angles_and_fade_core: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int pick_gap(bit busy);
      int roll;
      if (!busy) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_request(logic [15:0] tod, int gap);
      pending.push_back('{ENTRY_REQUEST, tod, 3'd0, 17'd0, gap});
   endtask

   task automatic queue_write(logic [2:0] index, int value);
      pending.push_back('{ENTRY_WRITE, 16'd0, index, 17'(value), 0});
   endtask

   task automatic queue_settings(int lat, int yaw, int band, int sp, int mp, int off,
                                 int tilt);
      queue_write(REG_LATITUDE, lat);
      queue_write(REG_COMPASS_YAW, yaw);
      queue_write(REG_BAND, band);
      queue_write(REG_SUN_PEAK, sp);
      queue_write(REG_MOON_PEAK, mp);
      queue_write(REG_MOON_OFFSET, off);
      queue_write(REG_MOON_TILT, tilt);
   endtask

   initial begin
      logic [15:0] directed[] = '{16'd0, 16'd1, 16'd12288, 16'd24576, 16'd36864,
                                  16'd49151, 16'd49152, 16'd65535, 16'hAAAA, 16'h5555,
                                  16'd24575, 16'd24577, 16'd6144, 16'd43008};
      bit busy;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset defaults, then zero latitude
      foreach (directed[i]) queue_request(directed[i], 0);
      queue_settings(0, 0, 0, 65535, 65535, 0, 0);
      foreach (directed[i]) queue_request(directed[i], i % 2);
      // out-of-range index write must be ignored
      queue_write(REG_UNUSED, 17'h1FFFF);
      queue_settings(11520, 23040, 11520, 65535, 0, 49152, 11520);
      for (int i = 0; i < 6; i++) queue_request(directed[i], 0);
      queue_settings(-11520, -23040, 1, 0, 65535, -49152, -11520);
      for (int i = 6; i < 12; i++) queue_request(directed[i], 0);

      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: queue_settings(11520, 0, 768, 2560, 51, 24576, -11520);
            1: queue_settings(-11520, 23040, 0, 65535, 65535, -49152, 11520);
            2: queue_settings(0, -23040, 11520, 0, 1, 49152, 0);
            default: queue_settings(pick(-11520, 11520), pick(-23040, 23040),
                                    pick(0, 3) == 0 ? pick(0, 11520) : pick(0, 1500),
                                    pick(0, 65535), pick(0, 65535), pick(-49152, 49152),
                                    pick(-11520, 11520));
         endcase
         busy = (ph % 3) != 1;
         for (int i = 0; i < 105; i++) begin
            queue_request(16'($urandom_range(0, 65535)), pick_gap(busy));
            if (ph == 6 && i == 50) pending.push_back('{ENTRY_DRAIN, 16'd0, 3'd0, 17'd0, 0});
         end
      end

      while (pending.size() > 0 || sky_expected.size() > 0 || req_tvalid) @(posedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0 && sky_expected.size() == 0) begin
         $display("** sun_moon_angles_and_fade_core: PASSED **");
      end else begin
         $display("** sun_moon_angles_and_fade_core: FAILED **");
      end
      $finish;
   end

endmodule
